// ----- design/bda_pkg.sv -----
// Shared types and constants for the button debounce and auto-repeat unit.
// No dependencies; imported by every module of the block.
package bda_pkg;

  localparam int FIELD_W = 3;
  localparam int CNT_W   = 16;

  localparam logic [CNT_W-1:0] HOLD_RESET   = 16'd100;
  localparam logic [CNT_W-1:0] REPEAT_RESET = 16'd20;

  localparam logic REG_HOLD   = 1'b0;
  localparam logic REG_REPEAT = 1'b1;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic pressed;
    logic long_held;
    logic pending;
  } lane_status_t;

  typedef struct packed {
    logic               event_res;
    logic [FIELD_W-1:0] pressed_levels;
    logic [FIELD_W-1:0] long_held;
    logic [FIELD_W-1:0] pending_events;
  } result_t;

endpackage

// ----- design/bda_lane.sv -----
// One button lane: sample history, debounce, press machine, hold/repeat counters.
// Depends on bda_pkg.
module bda_lane (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     tick,
  input  logic                     clear,
  input  logic                     sample,
  input  logic [15:0]              hold_ticks,
  input  logic [15:0]              repeat_ticks,
  output logic                     pend_now,
  output bda_pkg::lane_status_t    status
);
  import bda_pkg::*;

  localparam logic [1:0] ST_RELEASED = 2'd0;
  localparam logic [1:0] ST_PRESSED  = 2'd1;
  localparam logic [1:0] ST_LONG     = 2'd2;

  logic [1:0]       hist, hist_next;
  logic             stable, stable_next;
  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] hold_cnt, hold_cnt_next;
  logic [CNT_W-1:0] rep_cnt, rep_cnt_next;
  logic             pend, pend_next;
  logic             down;

  assign down = ~sample;

  always_comb begin
    hist_next     = hist;
    stable_next   = stable;
    state_next    = state;
    hold_cnt_next = hold_cnt;
    rep_cnt_next  = rep_cnt;
    pend_next     = pend;
    if (tick) begin
      hist_next = {hist[0], sample};
      if ((sample == hist[0]) && (hist[0] == hist[1])) begin
        stable_next = sample;
        case (state)
          ST_RELEASED: begin
            if (down) begin
              state_next    = ST_PRESSED;
              hold_cnt_next = '0;
              pend_next     = 1'b1;
            end
          end
          ST_PRESSED: begin
            if (!down) begin
              state_next    = ST_RELEASED;
              pend_next     = 1'b0;
              hold_cnt_next = '0;
            end else if (hold_cnt < hold_ticks) begin
              hold_cnt_next = hold_cnt + 1'b1;
            end else begin
              pend_next     = 1'b1;
              rep_cnt_next  = '0;
              hold_cnt_next = '0;
              state_next    = ST_LONG;
            end
          end
          default: begin
            if (!down) begin
              state_next   = ST_RELEASED;
              pend_next    = 1'b0;
              rep_cnt_next = '0;
            end else if (rep_cnt < repeat_ticks) begin
              rep_cnt_next = rep_cnt + 1'b1;
            end else begin
              pend_next    = 1'b1;
              rep_cnt_next = '0;
            end
          end
        endcase
      end
    end else if (clear) begin
      pend_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist     <= '0;
      stable   <= 1'b0;
      state    <= ST_RELEASED;
      hold_cnt <= '0;
      rep_cnt  <= '0;
      pend     <= 1'b0;
    end else begin
      hist     <= hist_next;
      stable   <= stable_next;
      state    <= state_next;
      hold_cnt <= hold_cnt_next;
      rep_cnt  <= rep_cnt_next;
      pend     <= pend_next;
    end
  end

  assign pend_now          = pend;
  assign status.pressed    = ~stable_next;
  assign status.long_held  = (state_next == ST_LONG);
  assign status.pending    = pend_next;

endmodule

// ----- design/bda_merge.sv -----
// Merge stage: packs lane status into one result item and picks the read event.
// Depends on bda_pkg.
module bda_merge #(
  parameter int NUM_BUTTONS = 3
) (
  input  logic                                   mode,
  input  logic [1:0]                             button_index,
  input  logic [NUM_BUTTONS-1:0]                 pend_now,
  input  bda_pkg::lane_status_t [NUM_BUTTONS-1:0] status,
  output bda_pkg::result_t                       result
);
  import bda_pkg::*;

  localparam int OUT_LANES = (NUM_BUTTONS < FIELD_W) ? NUM_BUTTONS : FIELD_W;
  localparam int RD_LANES  = (NUM_BUTTONS < 4) ? NUM_BUTTONS : 4;

  always_comb begin
    result = '0;
    for (int i = 0; i < OUT_LANES; i++) begin
      result.pressed_levels[i] = status[i].pressed;
      result.long_held[i]      = status[i].long_held;
      result.pending_events[i] = status[i].pending;
    end
    if (mode == MODE_READ) begin
      for (int i = 0; i < RD_LANES; i++) begin
        if (button_index == 2'(i)) begin
          result.event_res = pend_now[i];
        end
      end
    end
  end

endmodule

// ----- design/button_debounce_autorepeat_unit.sv -----
// Top level: register port, button lanes, merge stage and output skid buffer.
// Depends on bda_pkg, bda_lane and bda_merge.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   input   | in_valid / in_stall  | mode, pin_levels, button_index
//   output  | out_valid / out_stall| event_res, pressed_levels, long_held,
//           |                      | pending_events
//   config  | psel/penable/pready  | paddr, pwdata, prdata (hold, repeat)
//
// One item per cycle while in_stall is low; every lane steps in the cycle of the
// transfer and the result is registered into the output or skid entry.
// A two-entry output (register plus skid) keeps input open while one result waits.
// in_stall rises only when both output entries are full.
// Reset is synchronous; all lanes come out in the released state with history cleared to zero.
module button_debounce_autorepeat_unit #(
  parameter int NUM_BUTTONS = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [2:0]  pin_levels,
  input  logic [1:0]  button_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        event_res,
  output logic [2:0]  pressed_levels,
  output logic [2:0]  long_held,
  output logic [2:0]  pending_events
);
  import bda_pkg::*;

  logic [CNT_W-1:0] hold_ticks;
  logic [CNT_W-1:0] repeat_ticks;
  logic             cfg_wr;

  logic                              in_fire;
  logic                              out_fire;
  logic [NUM_BUTTONS-1:0]            pend_now;
  lane_status_t [NUM_BUTTONS-1:0]    status;
  result_t                           result;
  result_t                           out_res;
  result_t                           skid_res;
  logic                              skid_valid;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks   <= HOLD_RESET;
      repeat_ticks <= REPEAT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_HOLD) begin
        hold_ticks <= pwdata[CNT_W-1:0];
      end else begin
        repeat_ticks <= pwdata[CNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_HOLD) begin
      prdata = {16'd0, hold_ticks};
    end else begin
      prdata = {16'd0, repeat_ticks};
    end
  end

  assign in_stall = skid_valid;
  assign in_fire  = in_valid & ~in_stall;
  assign out_fire = out_valid & ~out_stall;

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    logic sample;
    if (i < FIELD_W) begin : g_pin
      assign sample = pin_levels[i];
    end else begin : g_nopin
      assign sample = 1'b0;
    end
    bda_lane u_lane (
      .clk          (clk),
      .rst          (rst),
      .tick         (in_fire & (mode == MODE_TICK)),
      .clear        (in_fire & (mode == MODE_READ) && (32'(button_index) == i)),
      .sample       (sample),
      .hold_ticks   (hold_ticks),
      .repeat_ticks (repeat_ticks),
      .pend_now     (pend_now[i]),
      .status       (status[i])
    );
  end

  bda_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .mode         (mode),
    .button_index (button_index),
    .pend_now     (pend_now),
    .status       (status),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_fire || !out_valid) begin
      out_valid  <= skid_valid | in_fire;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire || !out_valid) begin
      out_res <= skid_valid ? skid_res : result;
    end
    if (out_valid && out_stall && in_fire) begin
      skid_res <= result;
    end
  end

  assign event_res      = out_res.event_res;
  assign pressed_levels = out_res.pressed_levels;
  assign long_held      = out_res.long_held;
  assign pending_events = out_res.pending_events;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without an output entry");

  a_skid_after_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid & out_stall))
    else $error("skid filled without a stalled output");

  a_long_is_pressed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_res.long_held & ~out_res.pressed_levels) == '0))
    else $error("long hold reported on a released button");

endmodule

// ----- dv/bda_event_checker.sv -----
// Transfer checker for button_debounce_autorepeat_unit: watches the register,
// input and output ports, predicts every result and compares it field by field.
// Depends on bda_pkg.
module bda_event_checker #(
  parameter int NUM_BUTTONS = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        mode,
  input  logic [2:0]  pin_levels,
  input  logic [1:0]  button_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        event_res,
  input  logic [2:0]  pressed_levels,
  input  logic [2:0]  long_held,
  input  logic [2:0]  pending_events,
  output int          outstanding,
  output int          mismatches,
  output int          checked,
  output int          long_entries
);
  import bda_pkg::*;

  typedef enum logic [1:0] {BTN_UP, BTN_DOWN, BTN_LONG} press_e;

  logic [CNT_W-1:0] hold_limit;
  logic [CNT_W-1:0] repeat_limit;
  logic [2:0]       history    [NUM_BUTTONS];
  logic             level      [NUM_BUTTONS];
  press_e           btn_state  [NUM_BUTTONS];
  logic [CNT_W-1:0] hold_cnt   [NUM_BUTTONS];
  logic [CNT_W-1:0] repeat_cnt [NUM_BUTTONS];
  logic             event_flag [NUM_BUTTONS];
  result_t          due_results[$];
  result_t          head_result;

  function automatic void step_press(int b);
    logic down;
    down = (level[b] == 1'b0);
    case (btn_state[b])
      BTN_UP: begin
        if (down) begin
          btn_state[b]  = BTN_DOWN;
          hold_cnt[b]   = '0;
          event_flag[b] = 1'b1;
        end
      end
      BTN_DOWN: begin
        if (!down) begin
          btn_state[b]  = BTN_UP;
          event_flag[b] = 1'b0;
          hold_cnt[b]   = '0;
        end else if (hold_cnt[b] < hold_limit) begin
          hold_cnt[b] = hold_cnt[b] + 1'b1;
        end else begin
          event_flag[b] = 1'b1;
          repeat_cnt[b] = '0;
          hold_cnt[b]   = '0;
          btn_state[b]  = BTN_LONG;
          long_entries++;
        end
      end
      default: begin
        if (!down) begin
          btn_state[b]  = BTN_UP;
          event_flag[b] = 1'b0;
          repeat_cnt[b] = '0;
        end else if (repeat_cnt[b] < repeat_limit) begin
          repeat_cnt[b] = repeat_cnt[b] + 1'b1;
        end else begin
          event_flag[b] = 1'b1;
          repeat_cnt[b] = '0;
        end
      end
    endcase
  endfunction

  function automatic result_t predict_status(logic m, logic [2:0] pins, logic [1:0] sel);
    result_t r;
    logic    s;
    r = '0;
    if (m == MODE_TICK) begin
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        s = (b < FIELD_W) ? pins[b] : 1'b0;
        history[b] = {history[b][1:0], s};
        if (history[b] == 3'b000 || history[b] == 3'b111) begin
          level[b] = s;
          step_press(b);
        end
      end
    end else if (sel < NUM_BUTTONS) begin
      r.event_res     = event_flag[sel];
      event_flag[sel] = 1'b0;
    end
    for (int b = 0; b < NUM_BUTTONS && b < FIELD_W; b++) begin
      r.pressed_levels[b] = !level[b];
      r.long_held[b]      = (btn_state[b] == BTN_LONG);
      r.pending_events[b] = event_flag[b];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatches++;
    if (mismatches <= 50)
      $display("%0t: %s got %0d, expected %0d", $time, field, got, want);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      hold_limit   = HOLD_RESET;
      repeat_limit = REPEAT_RESET;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        history[b]    = 3'b000;
        level[b]      = 1'b0;
        btn_state[b]  = BTN_UP;
        hold_cnt[b]   = '0;
        repeat_cnt[b] = '0;
        event_flag[b] = 1'b0;
      end
      due_results.delete();
    end else begin
      // compare before queuing, so a result can never match its own transfer
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing due, pending_events",
                          32'(pending_events), 0);
        end else begin
          head_result = due_results.pop_front();
          checked++;
          if (event_res !== head_result.event_res)
            report_mismatch("event_res", 32'(event_res), 32'(head_result.event_res));
          if (pressed_levels !== head_result.pressed_levels)
            report_mismatch("pressed_levels", 32'(pressed_levels),
                            32'(head_result.pressed_levels));
          if (long_held !== head_result.long_held)
            report_mismatch("long_held", 32'(long_held), 32'(head_result.long_held));
          if (pending_events !== head_result.pending_events)
            report_mismatch("pending_events", 32'(pending_events),
                            32'(head_result.pending_events));
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_HOLD, 2'b00})
          hold_limit = pwdata[CNT_W-1:0];
        else if (paddr == {REG_REPEAT, 2'b00})
          repeat_limit = pwdata[CNT_W-1:0];
      end
      if (in_valid && !in_stall)
        due_results.push_back(predict_status(mode, pin_levels, button_index));
    end
    outstanding <= due_results.size();
  end

endmodule

// ----- dv/tb_top.sv -----
// Top of the button_debounce_autorepeat_unit testbench: clock, reset, register
// writes, tick and read stimulus, output stalls and the verdict.
// Depends on bda_pkg, bda_event_checker and the block itself.
module tb_top;
  import bda_pkg::*;

  localparam int NUM_BUTTONS   = 3;
  localparam int STALL_LIMIT   = 2000;
  localparam int ITEMS_PER_SET = 72;
  localparam int NUM_SETS      = 8;
  localparam logic [2:0] HOLD_ADDR   = {REG_HOLD, 2'b00};
  localparam logic [2:0] REPEAT_ADDR = {REG_REPEAT, 2'b00};

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [2:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic        mode         = MODE_TICK;
  logic [2:0]  pin_levels   = 3'b111;
  logic [1:0]  button_index = 2'd0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic        event_res;
  logic [2:0]  pressed_levels;
  logic [2:0]  long_held;
  logic [2:0]  pending_events;
  logic        quiet        = 1'b0;

  int outstanding;
  int mismatches;
  int checked;
  int long_entries;
  int idle_cycles = 0;
  int items       = 0;
  int reads       = 0;
  int settings    = 0;

  int hold_set   [NUM_SETS] = '{0, 65535, 3, 1, 6, 0, 12, 100};
  int repeat_set [NUM_SETS] = '{0, 65535, 1, 4, 0, 2, 3, 20};

  button_debounce_autorepeat_unit #(.NUM_BUTTONS(NUM_BUTTONS)) u_dut (.*);

  bda_event_checker #(.NUM_BUTTONS(NUM_BUTTONS)) u_checker (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !rst && !quiet && ($urandom_range(0, 99) < 30);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("button_debounce_autorepeat_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input logic m, input logic [2:0] pins, input logic [1:0] sel);
    if (!quiet) begin
      while ($urandom_range(0, 99) < 30) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    mode         <= m;
    pin_levels   <= pins;
    button_index <= sel;
    do @(posedge clk); while (in_stall);
    items++;
    if (m == MODE_READ) reads++;
  endtask

  task automatic tick(input logic [2:0] pins);
    send_item(MODE_TICK, pins, 2'($urandom));
  endtask

  task automatic read_event(input logic [1:0] sel);
    send_item(MODE_READ, 3'($urandom), sel);
  endtask

  // hold input until every due result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic set_timing(input int hold, input int rep);
    apb_write(HOLD_ADDR, 32'(hold));
    apb_write(REPEAT_ADDR, 32'(rep));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings++;
  endtask

  // mostly clean presses and releases with reads, bounce and stray levels mixed in
  task automatic run_random(input int count);
    logic [2:0] held;
    logic [2:0] pins;
    int         flip_odds;
    held      = 3'($urandom);
    flip_odds = $urandom_range(6, 30);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 25) begin
        read_event(2'($urandom));
      end else begin
        for (int b = 0; b < 3; b++)
          if ($urandom_range(1, flip_odds) == 1) held[b] = ~held[b];
        pins = held;
        if ($urandom_range(0, 99) < 10)
          pins = pins ^ 3'($urandom);
        else if ($urandom_range(0, 99) < 4)
          pins = 3'($urandom);
        tick(pins);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset history reads as pressed: the first tick presses every button
    tick(3'b000);
    read_event(2'd0);
    read_event(2'd3);
    tick(3'b111);
    tick(3'b111);
    read_event(2'd1);
    tick(3'b111);
    read_event(2'd2);
    tick(3'b010);
    tick(3'b101);
    tick(3'b010);
    tick(3'b110);
    tick(3'b110);
    tick(3'b110);
    read_event(2'd0);
    read_event(2'd3);

    for (int k = 0; k < NUM_SETS; k++) begin
      drain();
      set_timing(hold_set[k], repeat_set[k]);
      quiet <= (k == 2);
      if (k == 0) begin
        tick(3'b111);
        tick(3'b111);
        tick(3'b111);
        tick(3'b000);
        tick(3'b000);
        tick(3'b000);
        tick(3'b000);
        read_event(2'd0);
        tick(3'b000);
        read_event(2'd1);
      end
      run_random(ITEMS_PER_SET);
    end

    drain();
    repeat (4) @(posedge clk);
    $display("covered %0d transfers (%0d reads) over %0d hold/repeat settings",
             items, reads, settings);
    $display("%0d results compared, %0d long-hold entries seen", checked, long_entries);
    if (mismatches == 0) begin
      $display("button_debounce_autorepeat_unit: match");
    end else begin
      $display("button_debounce_autorepeat_unit: mismatch");
    end
    $finish;
  end

endmodule
